/* design/chp_pkg.sv */
`default_nettype none

package chp_pkg;

  localparam int SizeBits = 32;
  localparam int LenBits  = 32;
  localparam int LfBits   = 2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [3:0] HexTen   = 4'd10;

  localparam logic [LfBits-1:0] LfMax = 2'd3;
  localparam logic [LfBits-1:0] LfEnd = 2'd2;

  typedef enum logic [1:0] {
    EV_SIZE = 2'd0,
    EV_END  = 2'd1,
    EV_ERR  = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] ch);
    hex_digit_t d;
    d.hit = 1'b0;
    d.val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d.hit = 1'b1;
      d.val = ch[3:0];
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      d.hit = 1'b1;
      d.val = ch[3:0] - 4'd1 + HexTen;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* design/chp_if.sv */
`default_nettype none

interface chp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface chp_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    event_kind;
  logic [chp_pkg::LenBits-1:0]   chunk_length;
  logic                          length_overflow;

  modport source (output valid, output event_kind, output chunk_length,
                  output length_overflow, input ready);
  modport sink   (input valid, input event_kind, input chunk_length,
                  input length_overflow, output ready);
endinterface

`default_nettype wire

/* design/chunked_header_parser.sv */
// Chunked body header parser.
// in_chan carries one header or trailer byte per request (valid/ready).
// out_chan carries events: chunk size ready, end of body or protocol error,
// each with the sticky overflow flag; a size event also carries the decoded length.
// Bytes that produce no event (digits, CR, blanks, extension text) are
// consumed silently.
// Throughput: one byte per cycle, sustained, with out_chan ready.
// Path: a byte taken from in_chan goes into the input register, then one pass of
// parser logic writes its event into the result register that drives out_chan.
// Stall: when out_chan holds an event and ready is low, the parser stage stops;
// one more byte can still sit in the input register, then in_chan.ready drops.
// Reset (rst_n low, synchronous): size, flags, trailer mode and linefeed count
// clear, both registers empty.
`default_nettype none

module chunked_header_parser (
  input  wire              clk,
  input  wire              rst_n,
  chp_in_if.sink           in_chan,
  chp_out_if.source        out_chan
);

  localparam int SB = chp_pkg::SizeBits;

  logic                         in_valid_r;
  logic [7:0]                   byte_r;

  logic [SB-1:0]                acc_r, acc_nxt;
  logic                         seen_r, seen_nxt;
  logic                         ext_r, ext_nxt;
  logic                         trailer_r, trailer_nxt;
  logic [chp_pkg::LfBits-1:0]   lf_cnt_r, lf_cnt_nxt;
  logic                         ovf_r, ovf_nxt;

  logic                         out_valid_r;
  chp_pkg::event_kind_t         out_kind_r, kind_nxt;
  logic [chp_pkg::LenBits-1:0]  out_len_r, len_nxt;
  logic                         out_ovf_r;

  logic                         emit;
  logic                         out_free;
  logic                         proc_go;
  chp_pkg::hex_digit_t          hd;
  logic [SB+chp_pkg::LenBits-1:0] acc_wide;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign proc_go       = in_valid_r && out_free;
  assign in_chan.ready = !in_valid_r || proc_go;

  assign hd       = chp_pkg::hex_decode(byte_r);
  assign acc_wide = {{chp_pkg::LenBits{1'b0}}, acc_r};

  always_comb begin
    acc_nxt     = acc_r;
    seen_nxt    = seen_r;
    ext_nxt     = ext_r;
    trailer_nxt = trailer_r;
    lf_cnt_nxt  = lf_cnt_r;
    ovf_nxt     = ovf_r;
    emit        = 1'b0;
    kind_nxt    = chp_pkg::EV_ERR;
    len_nxt     = '0;
    if (trailer_r) begin
      if (byte_r == chp_pkg::CH_LF) begin
        if (lf_cnt_r != chp_pkg::LfMax) begin
          lf_cnt_nxt = lf_cnt_r + 1'b1;
        end
        if (lf_cnt_nxt >= chp_pkg::LfEnd) begin
          emit     = 1'b1;
          kind_nxt = chp_pkg::EV_END;
        end
      end else if (byte_r != chp_pkg::CH_CR) begin
        lf_cnt_nxt = '0;
      end
    end else if (byte_r == chp_pkg::CH_LF) begin
      if (seen_r) begin
        seen_nxt = 1'b0;
        ext_nxt  = 1'b0;
        if (acc_r == '0) begin
          trailer_nxt = 1'b1;
          lf_cnt_nxt  = 2'd1;
        end else begin
          acc_nxt  = '0;
          emit     = 1'b1;
          kind_nxt = chp_pkg::EV_SIZE;
          len_nxt  = acc_wide[chp_pkg::LenBits-1:0];
        end
      end
    end else if (!ext_r) begin
      if (hd.hit) begin
        if (acc_r[SB-1 -: 4] != 4'd0) begin
          ovf_nxt = 1'b1;
        end
        acc_nxt  = {acc_r[SB-5:0], hd.val};
        seen_nxt = 1'b1;
      end else if (byte_r == chp_pkg::CH_CR || byte_r == chp_pkg::CH_SPACE ||
                   byte_r == chp_pkg::CH_TAB) begin
        emit = 1'b0;
      end else if (byte_r == chp_pkg::CH_SEMI && seen_r) begin
        ext_nxt = 1'b1;
      end else begin
        emit     = 1'b1;
        kind_nxt = chp_pkg::EV_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      ext_r       <= 1'b0;
      trailer_r   <= 1'b0;
      lf_cnt_r    <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (proc_go) begin
        acc_r       <= acc_nxt;
        seen_r      <= seen_nxt;
        ext_r       <= ext_nxt;
        trailer_r   <= trailer_nxt;
        lf_cnt_r    <= lf_cnt_nxt;
        ovf_r       <= ovf_nxt;
        out_valid_r <= emit;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      byte_r <= in_chan.byte_in;
    end
    if (proc_go && emit) begin
      out_kind_r <= kind_nxt;
      out_len_r  <= len_nxt;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.event_kind      = out_kind_r;
  assign out_chan.chunk_length    = out_len_r;
  assign out_chan.length_overflow = out_ovf_r;

`ifndef SYNTHESIS
  a_trailer_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    trailer_r |=> trailer_r)
    else $error("trailer mode left without reset");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  a_ext_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
    ext_r |-> seen_r)
    else $error("extension active without a size digit");

  a_lf_size_mode: assert property (@(posedge clk) disable iff (!rst_n)
    !trailer_r |-> lf_cnt_r == '0)
    else $error("linefeed count nonzero in size mode");

  a_end_in_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == chp_pkg::EV_END) |-> trailer_r)
    else $error("end of body reported outside trailer mode");
`endif

endmodule

`default_nettype wire
